// File: rtl/mexp_pkg.sv
// Shared types, constants and the control program of the modular exponentiation core.
package mexp_pkg;

	// Word width of base, exponent, modulus and residue.
	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(WORD_BITS);
	localparam int STEP_W    = 3;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [STEP_W-1:0]    step_t;

	// Program step addresses.
	localparam step_t StepIdle = 3'd0;
	localparam step_t StepRed  = 3'd1;
	localparam step_t StepSqr  = 3'd2;
	localparam step_t StepTest = 3'd3;
	localparam step_t StepMulb = 3'd4;
	localparam step_t StepNext = 3'd5;
	localparam step_t StepEmit = 3'd6;

	// What a step does to the datapath.
	typedef enum logic [2:0] {
		ACT_NOP,
		ACT_ACCEPT,
		ACT_MUL,
		ACT_SHIFT,
		ACT_EMIT
	} act_t;

	// Multiplicand source.
	typedef enum logic [1:0] {
		XS_ONE,
		XS_ACC,
		XS_R
	} xsel_t;

	// Multiplier source, scanned from the most significant bit.
	typedef enum logic {
		YS_BASE,
		YS_ACC
	} ysel_t;

	// Destination of a product.
	typedef enum logic {
		DST_R,
		DST_ACC
	} dst_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_EXP_ZERO,
		JC_BIT_CLEAR,
		JC_MORE
	} jcond_t;

	typedef struct packed {
		act_t   act;
		xsel_t  xsel;
		ysel_t  ysel;
		dst_t   dst;
		jcond_t cond;
		step_t  target;
	} ctrl_t;

	// Request to the modular multiplier.
	typedef struct packed {
		logic  start;
		word_t x;
		word_t y;
	} mm_req_t;

	// Control store: one control word per program step.
	function automatic ctrl_t mexp_rom(input step_t pc);
		ctrl_t w;
		w = '{act: ACT_NOP, xsel: XS_ONE, ysel: YS_BASE, dst: DST_ACC,
			cond: JC_NONE, target: StepIdle};
		unique case (pc)
			StepIdle: begin
				w.act    = ACT_ACCEPT;
				w.cond   = JC_EXP_ZERO;
				w.target = StepEmit;
			end
			StepRed: begin
				w.act  = ACT_MUL;
				w.xsel = XS_ONE;
				w.ysel = YS_BASE;
				w.dst  = DST_R;
			end
			StepSqr: begin
				w.act  = ACT_MUL;
				w.xsel = XS_ACC;
				w.ysel = YS_ACC;
				w.dst  = DST_ACC;
			end
			StepTest: begin
				w.cond   = JC_BIT_CLEAR;
				w.target = StepNext;
			end
			StepMulb: begin
				w.act  = ACT_MUL;
				w.xsel = XS_R;
				w.ysel = YS_ACC;
				w.dst  = DST_ACC;
			end
			StepNext: begin
				w.act    = ACT_SHIFT;
				w.cond   = JC_MORE;
				w.target = StepSqr;
			end
			StepEmit: begin
				w.act    = ACT_EMIT;
				w.cond   = JC_ALWAYS;
				w.target = StepIdle;
			end
			default: begin
				w.cond   = JC_ALWAYS;
				w.target = StepIdle;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/mexp_if.sv
// Handshake channels for the exponentiation requests and results.
interface mexp_req_if import mexp_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t base;
	word_t exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if import mexp_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t residue;

	modport source (output valid, output residue, input ready);
	modport sink (input valid, input residue, output ready);
endinterface

// File: rtl/mexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, double then add.
module mexp_mulmod import mexp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	input  word_t   m,
	output logic    done,
	output word_t   p
);

	word_t        acc_q;
	word_t        x_q;
	word_t        y_q;
	cnt_t         cnt_q;
	logic         run_q;
	logic         done_q;
	logic         mod_on;
	logic [WORD_BITS:0] dbl;
	logic [WORD_BITS:0] dbl_red;
	logic [WORD_BITS:0] sum;
	logic [WORD_BITS:0] sum_red;

	// A zero modulus means plain multiplication wrapped to the word width.
	assign mod_on = (m != '0);

	// Double the partial result, reduce, add the multiplicand if the bit is set, reduce.
	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_red = (mod_on && dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		sum     = {1'b0, dbl_red[WORD_BITS-1:0]}
			+ (y_q[WORD_BITS-1] ? {1'b0, x_q} : '0);
		sum_red = (mod_on && sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
	end

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			x_q   <= req.x;
			y_q   <= req.y;
			cnt_q <= cnt_t'(WORD_BITS - 1);
		end else if (run_q) begin
			acc_q <= sum_red[WORD_BITS-1:0];
			y_q   <= {y_q[WORD_BITS-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

// File: rtl/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: sequencer, datapath and modulus register.
//
// Usage: write the modulus through cfg_we / cfg_wdata while the core is idle;
// it resets to 1. Each request word on req carries a base and an exponent and
// produces one response word on rsp holding base^exponent mod modulus. A zero
// exponent gives 1 for any modulus; a zero modulus gives the plain power
// wrapped to 32 bits.
// Control is a seven-step microprogram: reduce the base, then for each of the
// 32 exponent bits, MSB first, square and multiply when the bit is set. Every
// modular product goes through the shared bit-serial multiplier at one
// multiplier bit per cycle. One request is processed at a time; req.ready
// is high only in the idle step.
// The result sits in an output register: the core takes the next request while
// a response waits, and only stalls in its final step if the previous
// response is still not taken. Reset clears the program counter, the response
// valid flag and sets the modulus to 1.
module modular_exponentiation_core import mexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  word_t cfg_wdata,
	mexp_req_if.sink   req,
	mexp_rsp_if.source rsp
);

	step_t   pc_q;
	logic    wait_q;
	logic    rsp_valid_q;
	word_t   modulus_q;
	word_t   base_q;
	word_t   exp_q;
	cnt_t    cnt_q;
	word_t   acc_q;
	word_t   r_q;
	word_t   rsp_q;
	ctrl_t   cw;
	logic    go;
	logic    jump;
	step_t   pc_next;
	mm_req_t mm_req;
	logic    mm_done;
	word_t   mm_p;

	// Fetch the control word of the current step.
	assign cw = mexp_rom(pc_q);

	// Step completion.
	always_comb begin
		go = 1'b0;
		unique case (cw.act)
			ACT_ACCEPT: go = req.valid;
			ACT_MUL:    go = wait_q && mm_done;
			ACT_EMIT:   go = !rsp_valid_q || rsp.ready;
			ACT_NOP:    go = 1'b1;
			ACT_SHIFT:  go = 1'b1;
			default:    go = 1'b1;
		endcase
	end

	// Jump condition evaluation.
	always_comb begin
		unique case (cw.cond)
			JC_NONE:      jump = 1'b0;
			JC_ALWAYS:    jump = 1'b1;
			JC_EXP_ZERO:  jump = (req.exponent == '0);
			JC_BIT_CLEAR: jump = !exp_q[WORD_BITS-1];
			JC_MORE:      jump = (cnt_q != '0);
			default:      jump = 1'b0;
		endcase
	end

	assign pc_next = !go ? pc_q : (jump ? cw.target : pc_q + 1'b1);

	// Multiplier start and operand selection.
	always_comb begin
		mm_req.start = (cw.act == ACT_MUL) && !wait_q;
		unique case (cw.xsel)
			XS_ONE:  mm_req.x = word_t'(1);
			XS_ACC:  mm_req.x = acc_q;
			XS_R:    mm_req.x = r_q;
			default: mm_req.x = word_t'(1);
		endcase
		unique case (cw.ysel)
			YS_BASE: mm_req.y = base_q;
			YS_ACC:  mm_req.y = acc_q;
			default: mm_req.y = base_q;
		endcase
	end

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.m      (modulus_q),
		.done   (mm_done),
		.p      (mm_p)
	);

	// Sequencer, response flag and modulus register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= StepIdle;
			wait_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			modulus_q   <= word_t'(1);
		end else begin
			pc_q <= pc_next;
			if (cw.act == ACT_MUL) begin
				wait_q <= !go;
			end
			if (cw.act == ACT_EMIT && go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (go) begin
			unique case (cw.act)
				ACT_ACCEPT: begin
					base_q <= req.base;
					exp_q  <= req.exponent;
					cnt_q  <= cnt_t'(WORD_BITS - 1);
					// Start from 1 mod m; a zero exponent returns 1 outright.
					acc_q  <= {{(WORD_BITS-1){1'b0}},
						(req.exponent == '0) || (modulus_q != word_t'(1))};
				end
				ACT_MUL: begin
					if (cw.dst == DST_R) begin
						r_q <= mm_p;
					end else begin
						acc_q <= mm_p;
					end
				end
				ACT_SHIFT: begin
					exp_q <= {exp_q[WORD_BITS-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
				end
				ACT_EMIT: rsp_q <= acc_q;
				ACT_NOP: ;
				default: ;
			endcase
		end
	end

	assign req.ready   = (cw.act == ACT_ACCEPT);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.residue = rsp_q;

endmodule

// File: verif/tb_modular_exponentiation_core.sv
// Testbench for the modular exponentiation core: directed, back-pressure and random checks.
`timescale 1ns / 100ps

module tb_modular_exponentiation_core import mexp_pkg::*; ();

	// One expected residue together with the operands that produced it.
	typedef struct {
		word_t base;
		word_t exponent;
		word_t modulus;
		word_t residue;
	} residue_expect_t;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	word_t cfg_wdata;

	mexp_req_if req_ch ();
	mexp_rsp_if rsp_ch ();

	modular_exponentiation_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	residue_expect_t pending_residues[$];
	word_t           modulus_shadow;
	bit              idling_on;
	int              hold_cycles;
	int              failures;

	// Clock with a 10 ns period.
	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Product of two reduced values, reduced again; a zero modulus wraps to the word width.
	function automatic logic [63:0] mul_reduce(logic [63:0] x, logic [63:0] y, word_t m);
		logic [63:0] prod;
		prod = x * y;
		if (m == '0) begin
			return {32'b0, prod[WORD_BITS-1:0]};
		end
		return prod % m;
	endfunction

	// Square-and-multiply over the exponent bits, most significant first.
	function automatic word_t predict_residue(word_t b, word_t e, word_t m);
		logic [63:0] acc;
		logic [63:0] r;
		if (e == '0) begin
			return word_t'(1);
		end
		if (m == '0) begin
			r   = {32'b0, b};
			acc = 64'd1;
		end else begin
			r   = {32'b0, word_t'(b % m)};
			acc = 64'd1 % m;
		end
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			acc = mul_reduce(acc, acc, m);
			if (e[i]) begin
				acc = mul_reduce(acc, r, m);
			end
		end
		return acc[WORD_BITS-1:0];
	endfunction

	// Offer one request word, with an occasional idle burst before it.
	task automatic send_word(word_t b, word_t e);
		residue_expect_t item;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.base     <= b;
		req_ch.exponent <= e;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		item.base     = b;
		item.exponent = e;
		item.modulus  = modulus_shadow;
		item.residue  = predict_residue(b, e, modulus_shadow);
		pending_residues.push_back(item);
	endtask

	// Stop offering words and wait until every expected residue has been taken.
	task automatic drain_residues();
		req_ch.valid <= 1'b0;
		while (pending_residues.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the modulus register; only called while the core is idle.
	task automatic write_modulus(word_t value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we         <= 1'b0;
		modulus_shadow = value;
	endtask

	// A random request with a bias toward the interesting base and exponent values.
	task automatic send_random_word();
		word_t b;
		word_t e;
		case ($urandom_range(0, 11))
			0: b = '0;
			1: b = word_t'(1);
			2: b = '1;
			3: b = modulus_shadow - 1;
			4: b = modulus_shadow;
			5: b = modulus_shadow + 1;
			default: b = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0: e = '0;
			1: e = '1;
			2: e = word_t'($urandom_range(1, 16));
			default: e = $urandom;
		endcase
		send_word(b, e);
	endtask

	// The reset value of the modulus is one.
	task automatic test_reset_modulus();
		send_word(word_t'(5), '0);
		send_word(word_t'(5), word_t'(7));
		send_word('1, '1);
		drain_residues();
	endtask

	// Extremes of the fields under the largest moduli and the smallest useful one.
	task automatic test_directed_extremes();
		write_modulus(32'hFFFF_FFFF);
		send_word('0, '0);
		send_word('0, word_t'(1));
		send_word('0, '1);
		send_word('1, word_t'(1));
		send_word(32'hFFFF_FFFE, '1);
		send_word(word_t'(1), '1);
		send_word(word_t'(2), word_t'(31));
		send_word(word_t'(2), word_t'(32));
		send_word(32'h8000_0000, 32'h5555_5555);
		send_word(32'h1234_5678, 32'hAAAA_AAAA);
		drain_residues();

		// Largest 32-bit prime: the base above the modulus is reduced first.
		write_modulus(32'hFFFF_FFFB);
		send_word(32'hFFFF_FFFC, word_t'(1));
		send_word(word_t'(2), 32'hFFFF_FFFA);
		send_word('1, '1);
		send_word(32'hFFFF_FFFA, word_t'(2));
		drain_residues();

		write_modulus(word_t'(2));
		send_word(word_t'(3), word_t'(1));
		send_word(word_t'(4), word_t'(9));
		send_word('1, '0);
		drain_residues();
	endtask

	// The receiver holds off for a long stretch so the core fills and stalls its input.
	task automatic test_backpressure();
		write_modulus(word_t'(65521));
		hold_cycles = 6000;
		send_word(word_t'(7), '0);
		send_word(word_t'(9), '0);
		send_word(word_t'(3), word_t'(1));
		send_word(word_t'(12345), '0);
		send_word(word_t'(65535), word_t'(3));
		send_word(word_t'(2), '0);
		drain_residues();
	endtask

	// Random words under a series of moduli, with idling on both sides.
	task automatic test_random_moduli();
		word_t m;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: m = $urandom | 32'h8000_0000;
				1: m = word_t'($urandom_range(1, 255));
				2: m = word_t'(1) << $urandom_range(0, 31);
				3: m = word_t'($urandom_range(256, 65535));
				default: m = 32'hFFFF_FFFF - word_t'($urandom_range(0, 15));
			endcase
			write_modulus(m);
			repeat (42) send_random_word();
			drain_residues();
		end
	endtask

	// The last stretch runs with both sides always ready.
	task automatic test_no_idling();
		idling_on = 1'b0;
		write_modulus($urandom_range(1, 32'hFFFF_FFFF));
		repeat (50) send_random_word();
		drain_residues();
	endtask

	// Response side: random stall bursts, plus the long hold when one is requested.
	initial begin
		int stall_left;
		stall_left    = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				stall_left  = hold_cycles;
				hold_cycles = 0;
			end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted residue word with the oldest expectation.
	always @(posedge clk) begin
		residue_expect_t item;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_residues.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected residue word %h at %0t", rsp_ch.residue, $realtime);
				end
			end else begin
				item = pending_residues.pop_front();
				if (rsp_ch.residue !== item.residue) begin
					failures++;
					if (failures <= 10) begin
						$display("residue mismatch: base %h exp %h mod %h expected %h got %h",
							item.base, item.exponent, item.modulus, item.residue,
							rsp_ch.residue);
					end
				end
			end
		end
	end

	// Main sequence.
	initial begin
		failures         = 0;
		hold_cycles      = 0;
		idling_on        = 1'b1;
		modulus_shadow   = word_t'(1);
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.base     <= '0;
		req_ch.exponent <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_modulus();
		test_directed_extremes();
		test_backpressure();
		test_random_moduli();
		test_no_idling();

		repeat (50) @(posedge clk);
		if (failures == 0) begin
			$display("tb_modular_exponentiation_core: PASS");
		end else begin
			$display("tb_modular_exponentiation_core: FAIL");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#40_000_000;
		$display("tb_modular_exponentiation_core: FAIL");
		$finish;
	end

endmodule
